// ----- design/gdo_pkg.sv -----
// Shared types, constants and calendar functions for the Gregorian date offset unit.
package gdo_pkg;

	// Default width of the day count that is used
	localparam int COUNT_BITS_DEF = 16;

	// Fixed field widths
	localparam int YEAR_IN_W  = 14;
	localparam int YEAR_OUT_W = 15;
	localparam int YEAR_W     = 16;
	localparam int MONTH_W    = 4;
	localparam int DAY_OUT_W  = 5;
	localparam int COUNT_IN_W = 16;
	localparam int MAG_W      = 15;
	localparam int REM_W      = 9;

	// Calendar constants
	localparam logic [MAG_W-1:0]   LEAP_CYCLE = MAG_W'(400);
	localparam logic [REM_W-1:0]   CENTURY    = REM_W'(100);
	localparam logic [MONTH_W-1:0] JANUARY    = MONTH_W'(1);
	localparam logic [MONTH_W-1:0] FEBRUARY   = MONTH_W'(2);
	localparam logic [MONTH_W-1:0] DECEMBER   = MONTH_W'(12);
	localparam logic [DAY_OUT_W-1:0] FEB_DAYS      = DAY_OUT_W'(28);
	localparam logic [DAY_OUT_W-1:0] FEB_LEAP_DAYS = DAY_OUT_W'(29);

	// Controller states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LEAP,
		ST_STEP,
		ST_HOLD
	} state_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic load;       // take a new beat, start leap test of the start year
		logic leap_step;  // two compare-subtract steps of the year mod 400 reduction
		logic step;       // move one month
		logic capture;    // load the result register
	} cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic leap_last;  // this leap step is the final one
		logic done;       // day lies inside the current month
		logic year_wrap;  // the next month step crosses a year boundary
	} status_t;

	// Length of a month; out-of-range codes never reach here
	function automatic logic [DAY_OUT_W-1:0] month_days(input logic leap,
			input logic [MONTH_W-1:0] month);
		logic [DAY_OUT_W-1:0] len;
		unique case (month)
			FEBRUARY:               len = leap ? FEB_LEAP_DAYS : FEB_DAYS;
			4'd4, 4'd6, 4'd9, 4'd11: len = DAY_OUT_W'(30);
			default:                len = DAY_OUT_W'(31);
		endcase
		return len;
	endfunction

	// Leap flag from the year magnitude reduced mod 400
	function automatic logic leap_of_rem(input logic [REM_W-1:0] r);
		logic by_four;
		logic century;
		by_four = (r[1:0] == 2'b00);
		century = (r == CENTURY) || (r == REM_W'(200)) || (r == REM_W'(300));
		return by_four && !century;
	endfunction

endpackage

// ----- design/gdo_datapath.sv -----
// Datapath: date registers, month stepping, leap reduction and result register.
module gdo_datapath #(
	parameter int COUNT_BITS = gdo_pkg::COUNT_BITS_DEF
) (
	input  logic                              clk,
	input  gdo_pkg::cmd_t                     cmd,
	output gdo_pkg::status_t                  status,
	input  logic                              in_sub,
	input  logic [gdo_pkg::YEAR_IN_W-1:0]     in_year,
	input  logic [gdo_pkg::MONTH_W-1:0]       in_month,
	input  logic [gdo_pkg::DAY_OUT_W-1:0]     in_day,
	input  logic [((COUNT_BITS < gdo_pkg::COUNT_IN_W) ? COUNT_BITS
		: gdo_pkg::COUNT_IN_W)-1:0]          in_count,
	output logic [gdo_pkg::YEAR_OUT_W-1:0]    res_year,
	output logic [gdo_pkg::MONTH_W-1:0]       res_month,
	output logic [gdo_pkg::DAY_OUT_W-1:0]     res_day
);

	localparam int CNT_W = (COUNT_BITS < gdo_pkg::COUNT_IN_W) ? COUNT_BITS
		: gdo_pkg::COUNT_IN_W;
	// Holds start_day + count and start_day - count
	localparam int DAY_W = CNT_W + 2;

	logic                             sub_q;
	logic signed [gdo_pkg::YEAR_W-1:0] year_q;
	logic [gdo_pkg::MONTH_W-1:0]      month_q;
	logic signed [DAY_W-1:0]          day_q;
	logic                             leap_q;
	logic [gdo_pkg::MAG_W-1:0]        rem_q;
	logic [1:0]                       pair_q;
	logic [gdo_pkg::YEAR_OUT_W-1:0]   res_year_q;
	logic [gdo_pkg::MONTH_W-1:0]      res_month_q;
	logic [gdo_pkg::DAY_OUT_W-1:0]    res_day_q;

	logic [gdo_pkg::MONTH_W-1:0]      month_clamp;
	logic [DAY_W-1:0]                 day_ext;
	logic [DAY_W-1:0]                 cnt_ext;
	logic [gdo_pkg::MONTH_W-1:0]      month_prev;
	logic [gdo_pkg::DAY_OUT_W-1:0]    len_cur;
	logic [gdo_pkg::DAY_OUT_W-1:0]    len_prev;
	logic signed [DAY_W-1:0]          len_cur_ext;
	logic                             wrap;
	logic signed [gdo_pkg::YEAR_W-1:0] year_nxt;
	logic signed [gdo_pkg::YEAR_W-1:0] year_neg;
	logic [gdo_pkg::MAG_W-1:0]        mag_nxt;
	logic [gdo_pkg::MAG_W-1:0]        sub_hi;
	logic [gdo_pkg::MAG_W-1:0]        sub_lo;
	logic [gdo_pkg::MAG_W-1:0]        rem_a;
	logic [gdo_pkg::MAG_W-1:0]        rem_b;

	// Input conditioning: clamp month, widen day and count
	always_comb begin
		if (in_month < gdo_pkg::JANUARY) begin
			month_clamp = gdo_pkg::JANUARY;
		end else if (in_month > gdo_pkg::DECEMBER) begin
			month_clamp = gdo_pkg::DECEMBER;
		end else begin
			month_clamp = in_month;
		end
		day_ext = DAY_W'(in_day);
		cnt_ext = DAY_W'(in_count);
	end

	// Month lengths and year change for the next step
	always_comb begin
		month_prev  = (month_q == gdo_pkg::JANUARY) ? gdo_pkg::DECEMBER
			: month_q - gdo_pkg::MONTH_W'(1);
		len_cur     = gdo_pkg::month_days(leap_q, month_q);
		len_prev    = gdo_pkg::month_days(leap_q, month_prev);
		len_cur_ext = signed'(DAY_W'(len_cur));
		wrap        = sub_q ? (month_q == gdo_pkg::JANUARY) : (month_q == gdo_pkg::DECEMBER);
		year_nxt    = sub_q ? year_q - gdo_pkg::YEAR_W'(1) : year_q + gdo_pkg::YEAR_W'(1);
		year_neg    = -year_nxt;
		mag_nxt     = year_nxt[gdo_pkg::YEAR_W-1] ? year_neg[gdo_pkg::MAG_W-1:0]
			: year_nxt[gdo_pkg::MAG_W-1:0];
	end

	// Two restoring steps of |year| mod 400 per cycle
	always_comb begin
		sub_hi = gdo_pkg::LEAP_CYCLE << {pair_q, 1'b1};
		sub_lo = gdo_pkg::LEAP_CYCLE << {pair_q, 1'b0};
		rem_a  = (rem_q >= sub_hi) ? rem_q - sub_hi : rem_q;
		rem_b  = (rem_a >= sub_lo) ? rem_a - sub_lo : rem_a;
	end

	assign status.leap_last = (pair_q == 2'd0);
	assign status.done      = sub_q ? (day_q > signed'(DAY_W'(0))) : (day_q <= len_cur_ext);
	assign status.year_wrap = wrap;

	// Date registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sub_q   <= in_sub;
			year_q  <= signed'(gdo_pkg::YEAR_W'(in_year));
			month_q <= month_clamp;
			day_q   <= signed'(in_sub ? day_ext - cnt_ext : day_ext + cnt_ext);
		end else if (cmd.step) begin
			if (sub_q) begin
				day_q   <= day_q + signed'(DAY_W'(len_prev));
				month_q <= month_prev;
			end else begin
				day_q   <= day_q - len_cur_ext;
				month_q <= wrap ? gdo_pkg::JANUARY : month_q + gdo_pkg::MONTH_W'(1);
			end
			if (wrap) begin
				year_q <= year_nxt;
			end
		end
	end

	// Leap reduction registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rem_q  <= gdo_pkg::MAG_W'(in_year);
			pair_q <= 2'd2;
		end else if (cmd.step && wrap) begin
			rem_q  <= mag_nxt;
			pair_q <= 2'd2;
		end else if (cmd.leap_step) begin
			rem_q  <= rem_b;
			pair_q <= pair_q - 2'd1;
			if (pair_q == 2'd0) begin
				leap_q <= gdo_pkg::leap_of_rem(rem_b[gdo_pkg::REM_W-1:0]);
			end
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			res_year_q  <= year_q[gdo_pkg::YEAR_OUT_W-1:0];
			res_month_q <= month_q;
			res_day_q   <= day_q[gdo_pkg::DAY_OUT_W-1:0];
		end
	end

	assign res_year  = res_year_q;
	assign res_month = res_month_q;
	assign res_day   = res_day_q;

endmodule

// ----- design/gdo_ctrl.sv -----
// Controller: sequences load, leap reduction, month steps and result hand-off.
module gdo_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	input  gdo_pkg::status_t status,
	output gdo_pkg::cmd_t    cmd
);

	gdo_pkg::state_t state_q;
	gdo_pkg::state_t state_nxt;
	logic            out_valid_q;
	logic            out_free;

	assign out_free = !out_valid_q || out_ready;

	// State register and output valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= gdo_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.capture) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Next state and commands
	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		unique case (state_q)
			gdo_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load  = 1'b1;
					state_nxt = gdo_pkg::ST_LEAP;
				end
			end
			gdo_pkg::ST_LEAP: begin
				cmd.leap_step = 1'b1;
				if (status.leap_last) begin
					state_nxt = gdo_pkg::ST_STEP;
				end
			end
			gdo_pkg::ST_STEP: begin
				if (status.done) begin
					if (out_free) begin
						cmd.capture = 1'b1;
						state_nxt   = gdo_pkg::ST_IDLE;
					end else begin
						state_nxt = gdo_pkg::ST_HOLD;
					end
				end else begin
					cmd.step = 1'b1;
					if (status.year_wrap) begin
						state_nxt = gdo_pkg::ST_LEAP;
					end
				end
			end
			gdo_pkg::ST_HOLD: begin
				if (out_free) begin
					cmd.capture = 1'b1;
					state_nxt   = gdo_pkg::ST_IDLE;
				end
			end
			default: state_nxt = gdo_pkg::ST_IDLE;
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

// ----- design/gregorian_date_offset_unit.sv -----
// Per beat: a load, the leap reduction of the start year, one month step per month crossed, and a
// new leap reduction per year crossed, then the capture. A 65535-day count needs about 2160 month
// steps and 180 years; the month-step loop in the datapath sets the run time. One item is in work
// at a time, and the next beat is accepted while a finished result waits in the output register.
// Reset (arst_n, asynchronous, active low) clears the controller and the output valid;
// date and result registers take no reset.
module gregorian_date_offset_unit #(
	parameter int COUNT_BITS = gdo_pkg::COUNT_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [13:0] start_year, [17:14] start_month, [22:18] start_day, [38:23] day_count, [39] zero
	input  logic [39:0] s_axis_tdata,
	// [0] opcode
	input  logic        s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [14:0] result_year, [18:15] result_month, [23:19] result_day
	output logic [23:0] m_axis_tdata
);

	localparam int CNT_W = (COUNT_BITS < gdo_pkg::COUNT_IN_W) ? COUNT_BITS
		: gdo_pkg::COUNT_IN_W;

	gdo_pkg::cmd_t    cmd;
	gdo_pkg::status_t status;

	logic [gdo_pkg::YEAR_OUT_W-1:0] res_year;
	logic [gdo_pkg::MONTH_W-1:0]    res_month;
	logic [gdo_pkg::DAY_OUT_W-1:0]  res_day;

	// Sequencer
	gdo_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.status    (status),
		.cmd       (cmd)
	);

	// Date arithmetic
	gdo_datapath #(
		.COUNT_BITS (COUNT_BITS)
	) u_datapath (
		.clk       (clk),
		.cmd       (cmd),
		.status    (status),
		.in_sub    (s_axis_tuser),
		.in_year   (s_axis_tdata[13:0]),
		.in_month  (s_axis_tdata[17:14]),
		.in_day    (s_axis_tdata[22:18]),
		.in_count  (s_axis_tdata[23 +: CNT_W]),
		.res_year  (res_year),
		.res_month (res_month),
		.res_day   (res_day)
	);

	assign m_axis_tdata = {res_day, res_month, res_year};

endmodule
